// ===== hdl/pfss_pkg.sv =====
package pfss_pkg;

   // Field widths of the request and response records.
   localparam int CHAR_W   = 8;
   localparam int SLOT_W   = 6;
   localparam int TEXT_W   = 12;
   localparam int STATUS_W = 4;
   localparam int COUNT_W  = 7;

   // Default sizing of the scanner.
   localparam int DEF_MAX_SLOTS      = 64;
   localparam int DEF_MAX_STRING_LEN = 4096;
   localparam int DEF_QUEUE_DEPTH    = 4;

   // Reset value of the slot limit register.
   localparam logic [COUNT_W-1:0] MAX_SPECS_RESET = COUNT_W'(64);

   // Characters the grammar looks for.
   localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;  // '%'
   localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;  // '.'
   localparam logic [CHAR_W-1:0] CH_H     = 8'h68;  // 'h'
   localparam logic [CHAR_W-1:0] CH_L     = 8'h6C;  // 'l'
   localparam logic [CHAR_W-1:0] CH_UP_L  = 8'h4C;  // 'L'
   localparam logic [CHAR_W-1:0] CH_W     = 8'h77;  // 'w'
   localparam logic [CHAR_W-1:0] CH_Z     = 8'h7A;  // 'z'
   localparam logic [CHAR_W-1:0] CH_J     = 8'h6A;  // 'j'
   localparam logic [CHAR_W-1:0] CH_UP_I  = 8'h49;  // 'I'
   localparam logic [CHAR_W-1:0] CH_2     = 8'h32;  // '2'
   localparam logic [CHAR_W-1:0] CH_3     = 8'h33;  // '3'
   localparam logic [CHAR_W-1:0] CH_4     = 8'h34;  // '4'
   localparam logic [CHAR_W-1:0] CH_6     = 8'h36;  // '6'
   localparam logic [CHAR_W-1:0] CH_0     = 8'h30;  // '0'
   localparam logic [CHAR_W-1:0] CH_1     = 8'h31;  // '1'
   localparam logic [CHAR_W-1:0] CH_9     = 8'h39;  // '9'
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;  // '+'
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;  // '-'
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;  // ' '
   localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;  // '#'

   // Record kinds.
   localparam logic KIND_SPEC   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // How the argument of a spec is saved.
   typedef enum logic [1:0] {
      CLS_DIRECT = 2'd0,
      CLS_STRING = 2'd1,
      CLS_ARRAY  = 2'd2,
      CLS_DUMMY  = 2'd3
   } pfss_class_type;

   // Status codes latched by the scanner.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 4'd0,
      ST_TOO_MANY   = 4'd1,
      ST_END_FLAGS  = 4'd2,
      ST_END_WIDTH  = 4'd3,
      ST_END_PREC   = 4'd4,
      ST_BAD_I3     = 4'd5,
      ST_BAD_I6     = 4'd6,
      ST_END_LENGTH = 4'd7,
      ST_BAD_PHASE  = 4'd8,
      ST_BAD_TYPE   = 4'd9
   } pfss_status_type;

   // One request: a byte of the format string.
   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              end_of_string;
   } pfss_req_type;

   // One response record.
   typedef struct packed {
      logic                record_kind;
      logic [1:0]          save_class;
      logic [SLOT_W-1:0]   slot_index;
      logic [TEXT_W-1:0]   text_start;
      logic [TEXT_W-1:0]   text_length;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  error_index;
      logic [COUNT_W-1:0]  slot_count;
      logic                last_result;
   } pfss_rsp_type;

   // Work handed from the scanner to the record emitter: up to three records.
   typedef struct packed {
      logic                has_spec;
      logic                has_dummy;
      logic                has_status;
      pfss_class_type      save_class;
      logic [SLOT_W-1:0]   slot_index;
      logic [TEXT_W-1:0]   text_start;
      logic [TEXT_W-1:0]   text_length;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  error_index;
      logic [COUNT_W-1:0]  slot_count;
   } pfss_job_type;

   // True when the character is a recognized type letter.
   function automatic logic type_known(input logic [CHAR_W-1:0] c);
      logic hit;
      case (c) inside
         8'h63, 8'h43, 8'h64, 8'h69, 8'h6F, 8'h75, 8'h78, 8'h58,
         8'h6D, 8'h66, 8'h65, 8'h45, 8'h67, 8'h47, 8'h6E, 8'h70,
         8'h73, 8'h53, 8'h74, 8'h41, 8'h42: hit = 1'b1;
         default:                          hit = 1'b0;
      endcase
      return hit;
   endfunction

   // Save class of a type letter; only meaningful when type_known is true.
   function automatic pfss_class_type type_class(input logic [CHAR_W-1:0] c);
      pfss_class_type cls;
      case (c) inside
         8'h73, 8'h53, 8'h74: cls = CLS_STRING;  // s S t
         8'h41, 8'h42:        cls = CLS_ARRAY;   // A B
         default:             cls = CLS_DIRECT;
      endcase
      return cls;
   endfunction

endpackage

// ===== hdl/printf_format_spec_scanner.sv =====
// Scanner for printf-style format strings, one byte per request.
// Request channel (req_valid/req_ready/req_data): a byte of the string and a flag
// marking the last byte. Response channel (rsp_valid/rsp_ready/rsp_data): spec
// records, a second counted-array record for A and B specs, and a status record
// on the last byte of each string; last_result marks the final record of a byte.
// csr_write_enable/csr_write_data set the slot limit (reset value 64); write it
// only while no string is in flight.
// Throughput: one byte per cycle while the queue is not full. The front scanner
// decides each byte as it is accepted; bytes that produce records hand a job to a
// four-entry queue, and the emitter sends one record per cycle while the receiver
// is ready; a byte with two or three records holds the emitter for each, and the
// queue absorbs the difference. A byte's job enters the queue as it is accepted;
// its first record moves from the queue head to the output register, which holds
// it when the receiver stalls; the queue fills and req_ready drops once it is full.
// Reset: synchronous; clears the scanner, the queue and the output, and sets the
// slot limit back to 64. After each status record the scanner starts a new string.
module printf_format_spec_scanner
   import pfss_pkg::*;
#(
   parameter int MAX_SLOTS      = DEF_MAX_SLOTS,
   parameter int MAX_STRING_LEN = DEF_MAX_STRING_LEN
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pfss_req_type       req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pfss_rsp_type       rsp_data,
   input  logic               csr_write_enable,
   input  logic [COUNT_W-1:0] csr_write_data
);

   logic         job_push;
   pfss_job_type job;
   logic         queue_full;
   logic         head_valid;
   logic         head_pop;
   pfss_job_type head;

   // Byte scanner and slot accounting.
   pfss_front #(
      .MAX_SLOTS      (MAX_SLOTS),
      .MAX_STRING_LEN (MAX_STRING_LEN)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .job_push         (job_push),
      .job              (job)
   );

   // Jobs waiting for the emitter.
   pfss_queue #(
      .DEPTH (DEF_QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (job),
      .full       (queue_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // Record emitter with the output register.
   pfss_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== hdl/pfss_front.sv =====
module pfss_front
   import pfss_pkg::*;
#(
   parameter int MAX_SLOTS      = DEF_MAX_SLOTS,
   parameter int MAX_STRING_LEN = DEF_MAX_STRING_LEN
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pfss_req_type       req_data,
   input  logic               csr_write_enable,
   input  logic [COUNT_W-1:0] csr_write_data,
   input  logic               queue_full,
   output logic               job_push,
   output pfss_job_type       job
);

   localparam int PW = $clog2(MAX_STRING_LEN);
   localparam logic [PW-1:0] POS_LAST = PW'(MAX_STRING_LEN - 1);
   localparam logic [PW:0]   STR_LEN  = (PW + 1)'(MAX_STRING_LEN);
   localparam int SlotCap = (MAX_SLOTS > 127) ? 127 : MAX_SLOTS;
   localparam logic [COUNT_W-1:0] SLOT_CAP = COUNT_W'(SlotCap);

   typedef enum logic [3:0] {
      PH_NORMAL, PH_PCT, PH_FLAGS, PH_WIDTH, PH_DOT, PH_PREC, PH_SIZE,
      PH_H, PH_L, PH_I, PH_I3, PH_I6, PH_TYPE
   } phase_type;

   typedef enum logic [2:0] {
      STG_NONE, STG_FLAGS, STG_WIDTH, STG_PREC, STG_SIZE, STG_TYPE
   } stage_type;

   phase_type          phase_ff, phase_in;
   logic [PW-1:0]      pos_ff, pos_in;
   logic [PW-1:0]      tstart_ff, tstart_in;
   logic               captured_ff, captured_in;
   logic [COUNT_W-1:0] used_ff, used_in;
   pfss_status_type    err_ff, err_in;
   logic [COUNT_W-1:0] err_idx_ff, err_idx_in;
   logic [COUNT_W-1:0] max_specs_ff, max_specs_in;

   logic               accept;
   logic               eos;
   logic [CHAR_W-1:0]  c;
   stage_type          stage;
   logic               take;
   phase_type          take_phase;
   pfss_status_type    take_code;
   logic               capture;
   logic               finish;
   logic               err_hit;
   pfss_status_type    err_code;
   logic               is_flag, is_wdig, is_dig;
   logic               size_hit;
   phase_type          size_next;
   logic               cls_ok;
   pfss_class_type     cls;
   logic [COUNT_W-1:0] limit;
   logic [PW-1:0]      pos_next;
   logic [PW-1:0]      start_eff;
   logic [PW-1:0]      text_len;
   logic [PW:0]        len_wrap;

   assign c         = req_data.ch;
   assign eos       = req_data.end_of_string;
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Character classes.
   assign is_flag = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_0) ||
                    (c == CH_SPACE) || (c == CH_HASH);
   assign is_wdig = (c >= CH_1) && (c <= CH_9);
   assign is_dig  = (c >= CH_0) && (c <= CH_9);
   assign cls_ok  = type_known(c);
   assign cls     = type_class(c);

   // Length modifier decode.
   always_comb begin
      size_hit  = 1'b1;
      size_next = PH_TYPE;
      case (c)
         CH_H:    size_next = PH_H;
         CH_L:    size_next = PH_L;
         CH_UP_L: size_next = PH_SIZE;
         CH_W:    size_next = PH_SIZE;
         CH_Z:    size_next = PH_TYPE;
         CH_J:    size_next = PH_TYPE;
         CH_UP_I: size_next = PH_I;
         default: size_hit  = 1'b0;
      endcase
   end

   // Slot limit, position arithmetic and the length of the spec text.
   assign limit     = (max_specs_ff < SLOT_CAP) ? max_specs_ff : SLOT_CAP;
   assign pos_next  = (pos_ff == POS_LAST) ? '0 : pos_ff + PW'(1);
   assign start_eff = captured_ff ? tstart_ff : pos_ff;
   assign len_wrap  = {1'b0, pos_next} + STR_LEN - {1'b0, start_eff};
   assign text_len  = (pos_next >= start_eff) ? (pos_next - start_eff) : PW'(len_wrap);

   // Grammar walk for one byte: decide which part of the spec it belongs to.
   always_comb begin
      stage      = STG_NONE;
      take       = 1'b0;
      take_phase = phase_ff;
      take_code  = ST_OK;
      capture    = 1'b0;
      finish     = 1'b0;
      err_hit    = 1'b0;
      err_code   = ST_OK;
      if (err_ff == ST_OK) begin
         case (phase_ff)
            PH_NORMAL: begin
               if (c == CH_PCT) begin
                  take       = 1'b1;
                  take_phase = PH_PCT;
               end
            end
            PH_PCT: begin
               if (c == CH_PCT) begin
                  take       = 1'b1;
                  take_phase = PH_NORMAL;
               end else begin
                  stage = STG_FLAGS;
               end
            end
            PH_FLAGS: stage = STG_FLAGS;
            PH_WIDTH: stage = STG_WIDTH;
            PH_DOT:   stage = STG_PREC;
            PH_PREC:  stage = STG_PREC;
            PH_SIZE:  stage = STG_SIZE;
            PH_H: begin
               if (c == CH_H) begin
                  take       = 1'b1;
                  take_phase = PH_TYPE;
                  take_code  = ST_END_LENGTH;
               end else begin
                  stage = STG_TYPE;
               end
            end
            PH_L: begin
               if (c == CH_L) begin
                  take       = 1'b1;
                  take_phase = PH_TYPE;
                  take_code  = ST_END_LENGTH;
               end else begin
                  stage = STG_TYPE;
               end
            end
            PH_I: begin
               if (c == CH_3) begin
                  take       = 1'b1;
                  take_phase = PH_I3;
                  take_code  = ST_END_LENGTH;
               end else if (c == CH_6) begin
                  take       = 1'b1;
                  take_phase = PH_I6;
                  take_code  = ST_END_LENGTH;
               end else begin
                  stage = STG_TYPE;
               end
            end
            PH_I3: begin
               if (c == CH_2) begin
                  take       = 1'b1;
                  take_phase = PH_TYPE;
                  take_code  = ST_END_LENGTH;
               end else begin
                  err_hit  = 1'b1;
                  err_code = ST_BAD_I3;
               end
            end
            PH_I6: begin
               if (c == CH_4) begin
                  take       = 1'b1;
                  take_phase = PH_TYPE;
                  take_code  = ST_END_LENGTH;
               end else begin
                  err_hit  = 1'b1;
                  err_code = ST_BAD_I6;
               end
            end
            PH_TYPE: stage = STG_TYPE;
            default: begin
               err_hit  = 1'b1;
               err_code = ST_BAD_PHASE;
            end
         endcase

         // Fall through the optional parts until one of them takes the byte.
         if (stage == STG_FLAGS) begin
            if (is_flag) begin
               take       = 1'b1;
               take_phase = PH_FLAGS;
               take_code  = ST_END_FLAGS;
               stage      = STG_NONE;
            end else begin
               stage = STG_WIDTH;
            end
         end
         if (stage == STG_WIDTH) begin
            if (is_wdig) begin
               take       = 1'b1;
               take_phase = PH_WIDTH;
               take_code  = ST_END_WIDTH;
               stage      = STG_NONE;
            end else if (c == CH_DOT) begin
               take       = 1'b1;
               take_phase = PH_DOT;
               take_code  = ST_END_PREC;
               stage      = STG_NONE;
            end else begin
               stage = STG_SIZE;
            end
         end
         if (stage == STG_PREC) begin
            if (is_dig) begin
               take       = 1'b1;
               take_phase = PH_PREC;
               take_code  = ST_END_PREC;
               stage      = STG_NONE;
            end else begin
               stage = STG_SIZE;
            end
         end
         if (stage == STG_SIZE) begin
            if (size_hit) begin
               take       = 1'b1;
               take_phase = size_next;
               take_code  = ST_END_LENGTH;
               capture    = 1'b1;
               stage      = STG_NONE;
            end else begin
               stage = STG_TYPE;
            end
         end
         if (stage == STG_TYPE) begin
            finish = 1'b1;
         end
      end
   end

   // Next state and the job for the record emitter.
   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      tstart_in    = tstart_ff;
      captured_in  = captured_ff;
      used_in      = used_ff;
      err_in       = err_ff;
      err_idx_in   = err_idx_ff;
      max_specs_in = csr_write_enable ? csr_write_data : max_specs_ff;
      job          = '0;
      if (accept) begin
         if (take) begin
            phase_in = take_phase;
            if (eos && take_code != ST_OK) begin
               err_in     = take_code;
               err_idx_in = used_ff;
            end
            if (capture) begin
               tstart_in   = pos_ff;
               captured_in = 1'b1;
            end
         end
         if (err_hit) begin
            err_in     = err_code;
            err_idx_in = used_ff;
         end
         // A known type letter closes the spec and claims one or two slots, as the limit allows.
         if (finish) begin
            if (!cls_ok) begin
               err_in     = ST_BAD_TYPE;
               err_idx_in = used_ff;
            end else begin
               if (used_ff >= limit) begin
                  err_in     = ST_TOO_MANY;
                  err_idx_in = used_ff + COUNT_W'(1);
               end else begin
                  job.has_spec    = 1'b1;
                  job.save_class  = cls;
                  job.slot_index  = SLOT_W'(used_ff);
                  job.text_start  = TEXT_W'(start_eff);
                  job.text_length = TEXT_W'(text_len);
                  used_in         = used_ff + COUNT_W'(1);
                  if (cls == CLS_ARRAY) begin
                     if (used_ff + COUNT_W'(1) >= limit) begin
                        err_in     = ST_TOO_MANY;
                        err_idx_in = used_ff + COUNT_W'(2);
                     end else begin
                        job.has_dummy = 1'b1;
                        used_in       = used_ff + COUNT_W'(2);
                     end
                  end
               end
               phase_in    = PH_NORMAL;
               captured_in = 1'b0;
               tstart_in   = '0;
            end
         end
         // The last byte reports status and starts a fresh string.
         if (eos) begin
            job.has_status  = 1'b1;
            job.status      = err_in;
            job.error_index = err_idx_in;
            job.slot_count  = (used_in < limit) ? used_in : limit;
            phase_in        = PH_NORMAL;
            pos_in          = '0;
            tstart_in       = '0;
            captured_in     = 1'b0;
            used_in         = '0;
            err_in          = ST_OK;
            err_idx_in      = '0;
         end else begin
            pos_in = pos_next;
         end
      end
   end

   assign job_push = accept && (job.has_spec || job.has_status);

   // Scanner state and the slot limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_NORMAL;
         pos_ff       <= '0;
         tstart_ff    <= '0;
         captured_ff  <= 1'b0;
         used_ff      <= '0;
         err_ff       <= ST_OK;
         err_idx_ff   <= '0;
         max_specs_ff <= MAX_SPECS_RESET;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         tstart_ff    <= tstart_in;
         captured_ff  <= captured_in;
         used_ff      <= used_in;
         err_ff       <= err_in;
         err_idx_ff   <= err_idx_in;
         max_specs_ff <= max_specs_in;
      end
   end

   // The last byte leaves the scanner as after reset.
   assert property (@(posedge clock) disable iff (reset)
      accept && eos |=> phase_ff == PH_NORMAL && pos_ff == '0 && used_ff == '0 &&
                        err_ff == ST_OK && !captured_ff)
      else $error("scanner state not cleared after end of string");

   // Once an error is latched, later bytes other than the last change neither the error nor the slots.
   assert property (@(posedge clock) disable iff (reset)
      accept && err_ff != ST_OK && !eos |=>
         used_ff == $past(used_ff) && err_ff == $past(err_ff) &&
         err_idx_ff == $past(err_idx_ff))
      else $error("scanner state moved after a latched error");

   // A counted-array slot only follows an array spec.
   assert property (@(posedge clock) disable iff (reset)
      job_push && job.has_dummy |-> job.has_spec && job.save_class == CLS_ARRAY)
      else $error("dummy slot without its array spec");

endmodule

// ===== hdl/pfss_queue.sv =====
module pfss_queue
   import pfss_pkg::*;
#(
   parameter int DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  pfss_job_type push_job,
   output logic         full,
   input  logic         pop,
   output logic         head_valid,
   output pfss_job_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   pfss_job_type       entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head       = entries_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== hdl/pfss_back.sv =====
module pfss_back
   import pfss_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  pfss_job_type head,
   output logic         head_pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output pfss_rsp_type rsp_data
);

   logic         spec_done_ff, spec_done_in;
   logic         dummy_done_ff, dummy_done_in;
   logic         rsp_valid_ff, rsp_valid_in;
   pfss_rsp_type rsp_data_ff, rsp_data_in;
   pfss_rsp_type rec;
   logic         rec_last;
   logic         rem_spec, rem_dummy;
   logic         load;

   assign rem_spec  = head.has_spec && !spec_done_ff;
   assign rem_dummy = head.has_dummy && !dummy_done_ff;

   // Pick the next record of the head job: spec, then dummy slot, then status.
   always_comb begin
      rec          = '0;
      rec.record_kind = KIND_SPEC;
      rec_last     = 1'b1;
      if (rem_spec) begin
         rec.save_class  = head.save_class;
         rec.slot_index  = head.slot_index;
         rec.text_start  = head.text_start;
         rec.text_length = head.text_length;
         rec_last        = !head.has_dummy && !head.has_status;
      end else if (rem_dummy) begin
         rec.save_class = CLS_DUMMY;
         rec.slot_index = head.slot_index + SLOT_W'(1);
         rec_last       = !head.has_status;
      end else begin
         rec.record_kind = KIND_STATUS;
         rec.status      = head.status;
         rec.error_index = head.error_index;
         rec.slot_count  = head.slot_count;
      end
      rec.last_result = rec_last;
   end

   assign load     = head_valid && (!rsp_valid_ff || rsp_ready);
   assign head_pop = load && rec_last;

   // Output register and progress through the head job.
   always_comb begin
      spec_done_in  = spec_done_ff;
      dummy_done_in = dummy_done_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rec;
         if (rec_last) begin
            spec_done_in  = 1'b0;
            dummy_done_in = 1'b0;
         end else if (rem_spec) begin
            spec_done_in = 1'b1;
         end else begin
            dummy_done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spec_done_ff  <= 1'b0;
         dummy_done_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         spec_done_ff  <= spec_done_in;
         dummy_done_ff <= dummy_done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The status record is always the last one of its request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.record_kind == KIND_STATUS |-> rsp_data.last_result)
      else $error("status record not marked last");

   // The counted-array slot carries no text.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.record_kind == KIND_SPEC && rsp_data.save_class == CLS_DUMMY
         |-> rsp_data.text_start == '0 && rsp_data.text_length == '0)
      else $error("dummy slot record carries text");

   // A job is retired only when there is one.
   assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("job retired from an empty queue");

endmodule
